// ----- design/rmq_pkg.sv -----
// Shared types and constants for the rotation-matrix-to-quaternion pipeline.
// No dependencies.
package rmq_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 18;
    localparam int UW        = 21;
    localparam int NW        = 19;
    localparam int XW        = 34;
    localparam int SW        = 17;
    localparam int RW        = 19;
    localparam int SQ_STEPS  = XW / 2;
    localparam int EW        = 20;
    localparam int PW        = 21;
    localparam int QW        = 18;
    localparam int DDW       = NW + FRAC_BITS + 1;
    localparam int NSTG      = 1 + SQ_STEPS + 1 + QW + 1;

    localparam logic signed [UW-1:0] ONE_U = UW'(2 ** FRAC_BITS);
    localparam logic signed [DW-1:0] Q_MAX = DW'(131071);
    localparam logic signed [DW-1:0] Q_MIN = DW'(-131072);
    localparam logic [QW-1:0]        MAG_MAX = QW'(131071);

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_DIAG0 = 2'd1,
        BR_DIAG1 = 2'd2,
        BR_DIAG2 = 2'd3
    } branch_t;

    typedef struct packed {
        branch_t    branch;
        logic [2:0] neg;
    } side_t;

    typedef logic [2:0][NW-1:0] mag3_t;

endpackage

// ----- design/rmq_div_pipe.sv -----
// Pipelined restoring divider: round(mag * 2^F / (4*root)), one quotient bit per stage.
// Depends on rmq_pkg.
module rmq_div_pipe
    import rmq_pkg::*;
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] mag,
    input  logic [SW-1:0] root,
    output logic [QW-1:0] quo,
    output logic          ovf
);

    logic [SW+1:0]  den;
    logic [EW-1:0]  e_next;
    logic [DDW-1:0] dd;

    logic [PW-1:0] p_reg   [0:QW];
    logic [QW-1:0] lo_reg  [0:QW];
    logic [QW-1:0] qo_reg  [0:QW];
    logic [EW-1:0] e_reg   [0:QW];
    logic          ovf_reg [0:QW];

    always_comb
    begin
        den    = (root == '0) ? (SW+2)'(1) : {root, 2'b00};
        e_next = {den, 1'b0};
        dd     = {mag, {(FRAC_BITS + 1){1'b0}}} + DDW'(den);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]   <= PW'(dd[DDW-1:QW]);
            lo_reg[0]  <= dd[QW-1:0];
            qo_reg[0]  <= '0;
            e_reg[0]   <= e_next;
            ovf_reg[0] <= (EW'(dd[DDW-1:QW]) >= e_next);
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [PW-1:0] trial;
        logic [PW-1:0] p_next;
        logic          bit_next;

        always_comb
        begin
            trial    = {p_reg[k][PW-2:0], lo_reg[k][QW-1]};
            bit_next = (trial >= PW'(e_reg[k]));
            p_next   = bit_next ? (trial - PW'(e_reg[k])) : trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[k+1]   <= p_next;
                lo_reg[k+1]  <= {lo_reg[k][QW-2:0], 1'b0};
                qo_reg[k+1]  <= {qo_reg[k][QW-2:0], bit_next};
                e_reg[k+1]   <= e_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign quo = qo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

// ----- design/rotation_matrix_to_quaternion_top.sv -----
// Rotation matrix (signed Q1.16) to unit quaternion, Shepperd's method, fully pipelined.
// Depends on rmq_pkg and rmq_div_pipe.
//
// Accepts one matrix per cycle while in_ready is high and returns one quaternion per
// matrix, in order, through 38 register stages: one decode stage, a 17-stage bit-pair
// square root, one divider setup stage, an 18-stage restoring divider (three in parallel)
// and one output stage. The whole pipeline holds when the output beat is not taken, so
// in_ready follows out_ready whenever the output register is full.
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [DW-1:0] r00,
    input  logic signed [DW-1:0] r01,
    input  logic signed [DW-1:0] r02,
    input  logic signed [DW-1:0] r10,
    input  logic signed [DW-1:0] r11,
    input  logic signed [DW-1:0] r12,
    input  logic signed [DW-1:0] r20,
    input  logic signed [DW-1:0] r21,
    input  logic signed [DW-1:0] r22,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [DW-1:0] qx,
    output logic signed [DW-1:0] qy,
    output logic signed [DW-1:0] qz,
    output logic signed [DW-1:0] qw,
    output logic [1:0]           branch_taken
);

    localparam int DSET = SQ_STEPS + 1;

    logic adv;
    logic [NSTG-1:0] vld_reg;

    logic signed [UW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [UW-1:0] t, u, ucl;
    logic signed [UW-1:0] n_a, n_b, n_c;
    branch_t              br_next;
    logic [XW-1:0]        x_next;
    mag3_t                mag_next;
    logic [2:0]           neg_next;

    logic [XW-1:0] sx_reg   [0:SQ_STEPS];
    logic [RW-1:0] sr_reg   [0:SQ_STEPS];
    logic [SW-1:0] sq_reg   [0:SQ_STEPS];
    mag3_t         mag_reg  [0:SQ_STEPS];
    side_t         side_reg [0:NSTG-2];
    logic [SW-1:0] root_reg [0:QW];

    logic [2:0][QW-1:0] quo;
    logic [2:0]         ovf;

    logic signed [DW-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [DW-1:0] qx_next, qy_next, qz_next, qw_next;
    logic [1:0]           br_reg;
    logic signed [DW-1:0] sa_next, sb_next, sc_next, sm_next;
    logic [2:0][DW-1:0]   slot_next;

    assign adv      = !vld_reg[NSTG-1] || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        e00 = UW'(r00); e01 = UW'(r01); e02 = UW'(r02);
        e10 = UW'(r10); e11 = UW'(r11); e12 = UW'(r12);
        e20 = UW'(r20); e21 = UW'(r21); e22 = UW'(r22);
        t   = e00 + e11 + e22 + ONE_U;
        priority if (t > 0)
            br_next = BR_TRACE;
        else if (e22 > ((e11 > e00) ? e11 : e00))
            br_next = BR_DIAG2;
        else if (e11 > e00)
            br_next = BR_DIAG1;
        else
            br_next = BR_DIAG0;
        unique case (br_next)
            BR_TRACE:
            begin
                u = t;
                n_a = e12 - e21; n_b = e20 - e02; n_c = e01 - e10;
            end
            BR_DIAG0:
            begin
                u = e00 - (e11 + e22) + ONE_U;
                n_a = e01 + e10; n_b = e02 + e20; n_c = e12 - e21;
            end
            BR_DIAG1:
            begin
                u = e11 - (e22 + e00) + ONE_U;
                n_a = e12 + e21; n_b = e10 + e01; n_c = e20 - e02;
            end
            default:
            begin
                u = e22 - (e00 + e11) + ONE_U;
                n_a = e20 + e02; n_b = e21 + e12; n_c = e01 - e10;
            end
        endcase
        ucl      = (u > 0) ? u : '0;
        x_next   = XW'($unsigned(ucl)) << (FRAC_BITS - 2);
        neg_next = {n_c[UW-1], n_b[UW-1], n_a[UW-1]};
        mag_next[0] = NW'(n_a[UW-1] ? -n_a : n_a);
        mag_next[1] = NW'(n_b[UW-1] ? -n_b : n_b);
        mag_next[2] = NW'(n_c[UW-1] ? -n_c : n_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg[0]   <= x_next;
            sr_reg[0]   <= '0;
            sq_reg[0]   <= '0;
            mag_reg[0]  <= mag_next;
            side_reg[0] <= '{branch: br_next, neg: neg_next};
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [RW+1:0] trial;
        logic [RW+1:0] cand;
        logic          take;

        always_comb
        begin
            trial = {sr_reg[k], sx_reg[k][XW-1:XW-2]};
            cand  = (RW+2)'({sq_reg[k], 2'b01});
            take  = (trial >= cand);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sr_reg[k+1]  <= take ? RW'(trial - cand) : RW'(trial);
                sq_reg[k+1]  <= {sq_reg[k][SW-2:0], take};
                sx_reg[k+1]  <= sx_reg[k] << 2;
                mag_reg[k+1] <= mag_reg[k];
            end
        end
    end

    for (genvar k = 0; k < NSTG - 2; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
                side_reg[k+1] <= side_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            root_reg[0] <= sq_reg[SQ_STEPS];
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_root
        always_ff @(posedge clk)
        begin
            if (adv)
                root_reg[k+1] <= root_reg[k];
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        rmq_div_pipe u_div
        (
            .clk  (clk),
            .en   (adv),
            .mag  (mag_reg[SQ_STEPS][c]),
            .root (sq_reg[SQ_STEPS]),
            .quo  (quo[c]),
            .ovf  (ovf[c])
        );

        logic [QW-1:0] qm;

        always_comb
        begin
            qm = ovf[c] ? '1 : quo[c];
            if (side_reg[NSTG-2].neg[c])
                slot_next[c] = (qm > MAG_MAX) ? Q_MIN : DW'(-qm);
            else
                slot_next[c] = (qm > MAG_MAX) ? Q_MAX : DW'(qm);
        end
    end

    always_comb
    begin
        sa_next = slot_next[0];
        sb_next = slot_next[1];
        sc_next = slot_next[2];
        sm_next = DW'(root_reg[QW]);
        unique case (side_reg[NSTG-2].branch)
            BR_TRACE:
            begin
                qx_next = sa_next; qy_next = sb_next; qz_next = sc_next; qw_next = sm_next;
            end
            BR_DIAG0:
            begin
                qx_next = sm_next; qy_next = sa_next; qz_next = sb_next; qw_next = sc_next;
            end
            BR_DIAG1:
            begin
                qy_next = sm_next; qz_next = sa_next; qx_next = sb_next; qw_next = sc_next;
            end
            default:
            begin
                qz_next = sm_next; qx_next = sa_next; qy_next = sb_next; qw_next = sc_next;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            qz_reg <= qz_next;
            qw_reg <= qw_next;
            br_reg <= side_reg[NSTG-2].branch;
        end
    end

    assign out_valid    = vld_reg[NSTG-1];
    assign qx           = qx_reg;
    assign qy           = qy_reg;
    assign qz           = qz_reg;
    assign qw           = qw_reg;
    assign branch_taken = br_reg;

`ifndef SYNTHESIS
    a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    a_trace_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken == BR_TRACE |-> !qw[DW-1])
        else $error("trace branch scalar negative");

    a_diag_main_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken == BR_DIAG0 |-> !qx[DW-1])
        else $error("diagonal main component negative");
`endif

endmodule
